@@ rtl/core/fpst_pkg.sv @@
// Shared types, register indexes, reset values and widths for the frustum cull pipeline.
package fpst_pkg;

    // Pipeline stage positions
    localparam int NUM_STAGES = 9;
    localparam int ST_OFFSET  = 0;   // offset from camera
    localparam int ST_PROD    = 1;   // axis component products
    localparam int ST_DOT     = 2;   // dot sums, sphere margins
    localparam int ST_PART    = 3;   // depth-scaled partial products
    localparam int ST_SUM     = 4;   // partial sums, depth flags
    localparam int ST_ZZ      = 5;   // full depth*slope terms
    localparam int ST_BOUND   = 6;   // widened / narrowed bounds
    localparam int ST_CMP     = 7;   // lateral compares
    localparam int ST_OUT     = 8;   // verdict output register

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_XY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Z      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_RIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_UP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_BACK      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_FAR       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPES         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_FACTORS = 3'd7;

    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
    localparam logic [1:0] VERDICT_INSIDE    = 2'd1;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

    // Q2.14 unit axes
    localparam logic [47:0] AXIS_RIGHT_RST = 48'h0000_0000_4000;
    localparam logic [47:0] AXIS_UP_RST    = 48'h0000_4000_0000;
    localparam logic [47:0] AXIS_BACK_RST  = 48'h4000_0000_0000;

    localparam int OFS_W   = 33;    // pos - cam
    localparam int PROD_W  = 49;    // offset * axis component
    localparam int DW      = 52;    // dot products, Q.30
    localparam int HALF_W  = 26;    // split of a dot product for wide multiplies
    localparam int PP_W    = 60;    // partial product width
    localparam int DEPTH_W = 48;    // depth bounds, Q.30
    localparam int MRG_W   = 63;    // radius * factor, Q.40
    localparam int RQ_W    = 45;    // radius in Q.30
    localparam int CW      = 120;   // lateral compare domain, Q.78

    typedef struct packed {
        logic [63:0] cam_pos_xy;
        logic [31:0] cam_pos_z;
        logic [47:0] axis_right;
        logic [47:0] axis_up;
        logic [47:0] axis_back;
        logic [63:0] near_far;
        logic [63:0] slopes;
        logic [63:0] sphere_factors;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cam_pos_xy:     64'd0,
        cam_pos_z:      32'd0,
        axis_right:     AXIS_RIGHT_RST,
        axis_up:        AXIS_UP_RST,
        axis_back:      AXIS_BACK_RST,
        near_far:       64'd0,
        slopes:         64'd0,
        sphere_factors: 64'd0
    };

    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;      // stage register loads this cycle
        logic [NUM_STAGES-1:0] valid;   // stage holds a request
    } pipe_ctrl_t;

    typedef struct packed {
        logic signed [DW-1:0] az;
        logic signed [DW-1:0] ax;
        logic signed [DW-1:0] ay;
        logic [MRG_W-1:0]     d1;
        logic [MRG_W-1:0]     d2;
        logic [RQ_W-1:0]      rq;
    } xform_t;

    typedef struct packed {
        logic                 depth_out;
        logic                 depth_in;
        logic signed [CW-1:0] wx;
        logic signed [CW-1:0] wy;
        logic signed [CW-1:0] b1o;
        logic signed [CW-1:0] b1i;
        logic signed [CW-1:0] b2o;
        logic signed [CW-1:0] b2i;
    } bound_t;

endpackage

@@ rtl/core/fpst_ctrl.sv @@
// Valid/ready control for the stage chain: per-stage valid bits and load enables.
module fpst_ctrl
    import fpst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_ready,
    output logic       in_ready,
    output pipe_ctrl_t pipe
);

    localparam int OCC_W = $clog2(NUM_STAGES + 1);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ld;

    // A stage loads when empty or when its content moves on; bubbles collapse.
    always_comb
    begin
        ld[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ld[k] = !valid_reg[k] || ld[k+1];
        end
        valid_next[0] = ld[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = ld[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = ld[0];
    assign pipe.ld    = ld;
    assign pipe.valid = valid_reg;

    logic [OCC_W-1:0] occ;
    logic             in_fire;
    logic             out_fire;

    assign occ      = OCC_W'($countones(valid_reg));
    assign in_fire  = in_valid && ld[0];
    assign out_fire = valid_reg[NUM_STAGES-1] && out_ready;

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !out_fire) |=> occ == $past(occ) + 1'b1)
        else $error("occupancy did not grow on accepted request");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_fire && out_fire) |=> occ == $past(occ) - 1'b1)
        else $error("occupancy did not shrink on delivered result");

    a_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire == out_fire) |=> occ == $past(occ))
        else $error("occupancy changed without net transfer");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !ld[0] |-> (&valid_reg))
        else $error("input stalled while a bubble is in the pipe");

endmodule

@@ rtl/core/fpst_xform.sv @@
// Front stages: camera offset, axis products and dot sums, sphere margins.
module fpst_xform
    import fpst_pkg::*;
(
    input  logic               clk,
    input  pipe_ctrl_t         pipe,
    input  cfg_t               cfg,
    input  logic               opcode,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [30:0]        radius,
    output xform_t             xf
);

    // offset stage
    logic signed [OFS_W-1:0] ofs_next [3];
    logic signed [OFS_W-1:0] ofs_reg  [3];
    logic [30:0]             r1_reg;

    // product stage; row 0 right, 1 up, 2 back
    logic signed [15:0]       axc      [3][3];
    logic signed [PROD_W-1:0] prod_next[3][3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic [30:0]              r2_reg;

    // dot stage
    logic signed [DW-1:0] sum_r;
    logic signed [DW-1:0] sum_u;
    logic signed [DW-1:0] sum_b;
    xform_t               xf_next;
    xform_t               xf_reg;

    always_comb
    begin
        ofs_next[0] = OFS_W'(pos_x) - OFS_W'($signed(cfg.cam_pos_xy[31:0]));
        ofs_next[1] = OFS_W'(pos_y) - OFS_W'($signed(cfg.cam_pos_xy[63:32]));
        ofs_next[2] = OFS_W'(pos_z) - OFS_W'($signed(cfg.cam_pos_z));
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            axc[0][j] = $signed(cfg.axis_right[16*j +: 16]);
            axc[1][j] = $signed(cfg.axis_up[16*j +: 16]);
            axc[2][j] = $signed(cfg.axis_back[16*j +: 16]);
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[a][j] = ofs_reg[j] * axc[a][j];
            end
        end
    end

    always_comb
    begin
        sum_r = prod_reg[0][0] + prod_reg[0][1] + prod_reg[0][2];
        sum_u = prod_reg[1][0] + prod_reg[1][1] + prod_reg[1][2];
        sum_b = prod_reg[2][0] + prod_reg[2][1] + prod_reg[2][2];
        xf_next.az = -sum_b;
        xf_next.ax = sum_r;
        xf_next.ay = sum_u;
        // full 63-bit products
        xf_next.d1 = {31'd0, cfg.sphere_factors[31:0]} * {32'd0, r2_reg};
        xf_next.d2 = {31'd0, cfg.sphere_factors[63:32]} * {32'd0, r2_reg};
        xf_next.rq = {r2_reg, 14'd0};
    end

    always_ff @(posedge clk)
    begin
        if (pipe.ld[ST_OFFSET])
        begin
            ofs_reg <= ofs_next;
            // point test runs as a sphere of zero radius
            r1_reg  <= opcode ? radius : 31'd0;
        end
        if (pipe.ld[ST_PROD])
        begin
            prod_reg <= prod_next;
            r2_reg   <= r1_reg;
        end
        if (pipe.ld[ST_DOT])
        begin
            xf_reg <= xf_next;
        end
    end

    assign xf = xf_reg;

endmodule

@@ rtl/core/fpst_bound.sv @@
// Middle stages: depth times slopes in split products, depth flags, lateral bounds.
module fpst_bound
    import fpst_pkg::*;
(
    input  logic       clk,
    input  pipe_ctrl_t pipe,
    input  cfg_t       cfg,
    input  xform_t     xf,
    output bound_t     bd
);

    // tan * ratio, registered every cycle from the slopes register
    logic [63:0] tr_reg;

    logic signed [HALF_W:0]   azl;
    logic signed [HALF_W-1:0] azh;
    logic signed [32:0]       trl;
    logic signed [32:0]       trh;
    logic signed [32:0]       tg;
    logic signed [DEPTH_W-1:0] farq;
    logic signed [DEPTH_W-1:0] nearq;
    logic signed [DEPTH_W-1:0] rqs;

    // partial product stage
    logic signed [PP_W-1:0]    pa_reg, pb_reg, pc_reg, pd_reg, qa_reg, qb_reg;
    logic signed [DEPTH_W-1:0] fo_reg, no_reg, fi_reg, ni_reg;
    logic signed [DW-1:0]      az4_reg, ax4_reg, ay4_reg;
    logic [MRG_W-1:0]          d1_4_reg, d2_4_reg;

    // partial sum stage
    logic signed [CW-1:0] pa_w, pb_w, pc_w, pd_w, qa_w, qb_w;
    logic signed [CW-1:0] zz1a_reg, zz1b_reg, zz2_5_reg;
    logic                 dout5_reg, din5_reg;
    logic signed [DW-1:0] ax5_reg, ay5_reg;
    logic [MRG_W-1:0]     d1_5_reg, d2_5_reg;

    // full term stage
    logic signed [CW-1:0] zz1_reg, zz2_6_reg;
    logic                 dout6_reg, din6_reg;
    logic signed [DW-1:0] ax6_reg, ay6_reg;
    logic [MRG_W-1:0]     d1_6_reg, d2_6_reg;

    // bound stage
    logic signed [CW-1:0] d1w, d2w, zz2s, axw, ayw;
    bound_t               bd_next;
    bound_t               bd_reg;

    always_comb
    begin
        azl   = $signed({1'b0, xf.az[HALF_W-1:0]});
        azh   = xf.az[DW-1:HALF_W];
        trl   = $signed({1'b0, tr_reg[31:0]});
        trh   = $signed({1'b0, tr_reg[63:32]});
        tg    = $signed({1'b0, cfg.slopes[31:0]});
        farq  = $signed({2'd0, cfg.near_far[63:32], 14'd0});
        nearq = $signed({2'd0, cfg.near_far[31:0], 14'd0});
        rqs   = $signed({3'd0, xf.rq});
    end

    always_comb
    begin
        pa_w = pa_reg;
        pb_w = pb_reg;
        pc_w = pc_reg;
        pd_w = pd_reg;
        qa_w = qa_reg;
        qb_w = qb_reg;
    end

    always_comb
    begin
        d1w  = $signed({{(CW-MRG_W-38){1'b0}}, d1_6_reg, 38'd0});
        d2w  = $signed({{(CW-MRG_W-38){1'b0}}, d2_6_reg, 38'd0});
        zz2s = zz2_6_reg <<< 24;
        axw  = ax6_reg;
        ayw  = ay6_reg;
        bd_next.depth_out = dout6_reg;
        bd_next.depth_in  = din6_reg;
        bd_next.wx  = axw <<< 48;
        bd_next.wy  = ayw <<< 48;
        bd_next.b1o = zz1_reg + d1w;
        bd_next.b1i = zz1_reg - d1w;
        bd_next.b2o = zz2s + d2w;
        bd_next.b2i = zz2s - d2w;
    end

    always_ff @(posedge clk)
    begin
        tr_reg <= cfg.slopes[31:0] * cfg.slopes[63:32];

        if (pipe.ld[ST_PART])
        begin
            pa_reg   <= azl * trl;
            pb_reg   <= azl * trh;
            pc_reg   <= azh * trl;
            pd_reg   <= azh * trh;
            qa_reg   <= azl * tg;
            qb_reg   <= azh * tg;
            fo_reg   <= farq + rqs;
            no_reg   <= nearq - rqs;
            fi_reg   <= farq - rqs;
            ni_reg   <= nearq + rqs;
            az4_reg  <= xf.az;
            ax4_reg  <= xf.ax;
            ay4_reg  <= xf.ay;
            d1_4_reg <= xf.d1;
            d2_4_reg <= xf.d2;
        end

        if (pipe.ld[ST_SUM])
        begin
            zz1a_reg  <= pa_w + (pb_w <<< 32);
            zz1b_reg  <= (pc_w <<< HALF_W) + (pd_w <<< (32 + HALF_W));
            zz2_5_reg <= qa_w + (qb_w <<< HALF_W);
            dout5_reg <= (az4_reg > fo_reg) || (az4_reg < no_reg);
            din5_reg  <= (az4_reg > fi_reg) || (az4_reg < ni_reg);
            ax5_reg   <= ax4_reg;
            ay5_reg   <= ay4_reg;
            d1_5_reg  <= d1_4_reg;
            d2_5_reg  <= d2_4_reg;
        end

        if (pipe.ld[ST_ZZ])
        begin
            zz1_reg   <= zz1a_reg + zz1b_reg;
            zz2_6_reg <= zz2_5_reg;
            dout6_reg <= dout5_reg;
            din6_reg  <= din5_reg;
            ax6_reg   <= ax5_reg;
            ay6_reg   <= ay5_reg;
            d1_6_reg  <= d1_5_reg;
            d2_6_reg  <= d2_5_reg;
        end

        if (pipe.ld[ST_BOUND])
        begin
            bd_reg <= bd_next;
        end
    end

    assign bd = bd_reg;

endmodule

@@ rtl/core/fpst_cmp.sv @@
// Back stages: lateral range compares and the verdict output register.
module fpst_cmp
    import fpst_pkg::*;
(
    input  logic       clk,
    input  pipe_ctrl_t pipe,
    input  bound_t     bd,
    output logic [1:0] verdict
);

    // x lies outside [-b, b]
    function automatic logic beyond(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] b);
        logic signed [CW-1:0] hi_d;
        logic signed [CW-1:0] lo_s;
        hi_d = b - x;
        lo_s = x + b;
        return hi_d[CW-1] || lo_s[CW-1];
    endfunction

    logic       out_fail_reg;
    logic       in_fail_reg;
    logic [1:0] verdict_reg;
    logic [1:0] verdict_next;

    always_comb
    begin
        if (out_fail_reg)
        begin
            verdict_next = VERDICT_OUTSIDE;
        end
        else if (in_fail_reg)
        begin
            verdict_next = VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.ld[ST_CMP])
        begin
            out_fail_reg <= bd.depth_out || beyond(bd.wx, bd.b1o) || beyond(bd.wy, bd.b2o);
            in_fail_reg  <= bd.depth_in  || beyond(bd.wx, bd.b1i) || beyond(bd.wy, bd.b2i);
        end
        if (pipe.ld[ST_OUT])
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign verdict = verdict_reg;

endmodule

@@ rtl/core/frustum_point_sphere_test.sv @@
// Top level of the point/sphere view frustum cull: config registers and pipeline.
//
//  channel   dir   handshake                  payload
//  -------   ---   ------------------------   ------------------------------------
//  in        in    in_valid / in_ready        opcode, pos_x, pos_y, pos_z, radius
//  out       out   out_valid / out_ready      verdict
//  cfg       in    cfg_write (no wait)        cfg_index, cfg_data
//
//  One request per cycle sustained while out_ready holds high; a request passes
//  through the nine-stage register chain (offset, products, dot sums, split wide
//  multiplies, partial sums, full sums, bounds, compares, output) before out_valid
//  rises for it.
//  rst_n clears the stage valid bits and loads the config reset values.
//  A stall at out_ready holds the output register; upstream stages keep
//  loading until the chain is full, so in_ready drops only when all 9 hold requests.
//  in_ready is combinational from out_ready through the stage chain.
module frustum_point_sphere_test
    import fpst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [31:0]    pos_z,
    input  logic [30:0]           radius,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            verdict,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    pipe_ctrl_t pipe;
    xform_t     xf;
    bound_t     bd;

    // Config writes must land only while the pipe is empty; the block does not enforce
    // this. The stages read cfg_reg directly; the bound unit registers tan*ratio from it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CAM_POS_XY:     cfg_reg.cam_pos_xy     <= cfg_data;
                REG_CAM_POS_Z:      cfg_reg.cam_pos_z      <= cfg_data[31:0];
                REG_AXIS_RIGHT:     cfg_reg.axis_right     <= cfg_data[47:0];
                REG_AXIS_UP:        cfg_reg.axis_up        <= cfg_data[47:0];
                REG_AXIS_BACK:      cfg_reg.axis_back      <= cfg_data[47:0];
                REG_NEAR_FAR:       cfg_reg.near_far       <= cfg_data;
                REG_SLOPES:         cfg_reg.slopes         <= cfg_data;
                REG_SPHERE_FACTORS: cfg_reg.sphere_factors <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Handshake and per-stage valid tracking
    fpst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .pipe      (pipe)
    );

    // Offset from camera and projection onto the three camera axes.
    // A point request enters with radius forced to zero, so its inner and
    // outer bounds coincide and it can never come out as intersect.
    fpst_xform u_xform (
        .clk    (clk),
        .pipe   (pipe),
        .cfg    (cfg_reg),
        .opcode (opcode),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .radius (radius),
        .xf     (xf)
    );

    // Depth range flags and lateral bounds in Q.78: depth*tan*ratio and
    // depth*tan are built from 26x32 partial products over three stages.
    fpst_bound u_bound (
        .clk  (clk),
        .pipe (pipe),
        .cfg  (cfg_reg),
        .xf   (xf),
        .bd   (bd)
    );

    // Outer bounds decide outside, inner bounds decide intersect.
    fpst_cmp u_cmp (
        .clk     (clk),
        .pipe    (pipe),
        .bd      (bd),
        .verdict (verdict)
    );

    assign out_valid = pipe.valid[ST_OUT];

endmodule
